>>> hdl/macro_argument_substituter_defines.svh
// assertion macros for the macro argument substituter
`ifndef MACRO_ARGUMENT_SUBSTITUTER_DEFINES_SVH
`define MACRO_ARGUMENT_SUBSTITUTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MAS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MAS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mas_pkg.sv
// types and constants of the macro argument substituter
`default_nettype none

package mas_pkg;

  localparam int NUM_ARGS_DEF = 10;
  localparam int ARG_LEN_DEF  = 32;

  localparam int LEN_W = 6;
  localparam int REF_W = 7;

  localparam logic [7:0] DOLLAR_CHAR   = 8'h24;
  localparam logic [7:0] DIGIT0_CHAR   = 8'h30;
  localparam int         RADIX         = 10;
  localparam int         ZERO_REF_SLOT = 9;

  typedef enum logic [1:0] {
    OP_ARG_BYTE  = 2'd0,
    OP_ARG_LEN   = 2'd1,
    OP_LINE_CHAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_TEXT   = 2'd0,
    PH_DOLLAR = 2'd1,
    PH_DIGIT  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LEN  = 2'd1,
    ST_EXP  = 2'd2,
    ST_TAIL = 2'd3
  } mas_state_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [3:0]       arg_slot;
    logic [4:0]       arg_pos;
    logic [LEN_W-1:0] arg_len;
    logic [7:0]       in_char;
    logic             line_end;
  } mas_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       bad_ref;
    logic       line_done;
  } mas_out_t;

endpackage

`default_nettype wire

>>> hdl/macro_argument_substituter.sv
// macro argument substituter: expands $n references in a character stream
// plain characters: result registered in the cycle after the transaction, one per cycle while the output is not stalled
// a '$' followed by a character other than a digit or '$' gives two results, the '$' and then that character
// a reference: ST_LEN reads the length memory, then ST_EXP gives one argument byte per cycle
// from the argument memory read port while the output is not stalled, and ST_TAIL gives any trailing character
// reset clears control and the argument length valid flags at once; argument bytes undefined until written
`default_nettype none
`include "macro_argument_substituter_defines.svh"

module macro_argument_substituter #(
  parameter int NUM_ARGS = mas_pkg::NUM_ARGS_DEF,
  parameter int ARG_LEN  = mas_pkg::ARG_LEN_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire mas_pkg::mas_in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output mas_pkg::mas_out_t    out_data_o
);

  import mas_pkg::*;

  localparam int SW    = $clog2(NUM_ARGS);
  localparam int LW    = $clog2(ARG_LEN + 1);
  localparam int DEPTH = NUM_ARGS * ARG_LEN;
  localparam int AW    = $clog2(DEPTH);

  mas_state_e       state_q, state_d;
  phase_e           phase_q, phase_d, phase_nx;
  logic [3:0]       held_q, held_d, held_nx;
  logic             drop_q, drop_d;
  logic [LW-1:0]    rem_q, rem_d;
  logic [LW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    base_q, base_d;
  logic             tail_vld_q, tail_vld_d;
  logic [7:0]       tail_chr_q, tail_chr_d;
  logic             last_q, last_d;
  mas_out_t         out_q, out_d;
  logic             out_vld_q, out_vld_d;

  logic [7:0]       arg_mem [DEPTH];
  logic [LW-1:0]    len_mem [NUM_ARGS];
  logic [NUM_ARGS-1:0] len_vld_q;
  logic [7:0]       arg_rd_q;
  logic [LW-1:0]    len_rd_q;
  logic             len_rd_vld_q;
  logic [LW-1:0]    len_eff;

  logic             in_accept;
  logic             can_load;
  logic             is_line;
  logic             last_in;
  logic             is_digit;
  logic             is_dol;
  logic [3:0]       dig;
  logic             dol1;
  logic             chr_emit;
  logic             need_ref;
  logic             ref_bad;
  logic [REF_W-1:0] ref_val;
  logic [SW-1:0]    ref_slot;
  logic             tail_vld_nx;
  logic [7:0]       tail_chr_nx;

  logic             arg_we, arg_re, len_we, len_re;
  logic [SW-1:0]    wr_slot;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic             slot_ok, pos_ok;
  logic [LW-1:0]    len_sat;

  function automatic mas_out_t mk_res(logic [7:0] ch, logic has, logic bad, logic done);
    mas_out_t r;
    r.out_char  = ch;
    r.has_char  = has;
    r.bad_ref   = bad;
    r.line_done = done;
    return r;
  endfunction

  assign can_load  = !out_vld_q || !out_stall_i;
  // transactions only in idle, so the memory ports never collide
  assign in_stall_o = !((state_q == ST_IDLE) && can_load);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign len_eff = len_rd_vld_q ? len_rd_q : '0;

  assign wr_slot = SW'(in_data_i.arg_slot);
  assign slot_ok = REF_W'(in_data_i.arg_slot) < REF_W'(NUM_ARGS);
  assign pos_ok  = {1'b0, in_data_i.arg_pos} < LEN_W'(ARG_LEN);
  assign len_sat = (in_data_i.arg_len > LEN_W'(ARG_LEN)) ? LW'(ARG_LEN) :
                   LW'(in_data_i.arg_len);
  assign wr_addr = AW'(wr_slot) * AW'(ARG_LEN) + AW'(in_data_i.arg_pos);
  assign rd_addr = base_q + AW'(pos_q);

  // line character decode
  always_comb begin
    is_line  = in_data_i.op == OP_LINE_CHAR;
    last_in  = in_data_i.line_end;
    dig      = 4'(in_data_i.in_char - DIGIT0_CHAR);
    is_digit = (in_data_i.in_char >= DIGIT0_CHAR) && (dig <= 4'(RADIX - 1))
               && (in_data_i.in_char < DIGIT0_CHAR + 8'(RADIX));
    is_dol   = in_data_i.in_char == DOLLAR_CHAR;
    dol1     = 1'b0;
    chr_emit = 1'b0;
    need_ref = 1'b0;
    ref_val  = '0;
    held_nx  = held_q;
    phase_nx = PH_TEXT;
    unique case (phase_q)
      PH_DOLLAR: begin
        if (is_digit) begin
          held_nx  = dig;
          phase_nx = PH_DIGIT;
          need_ref = last_in;
          ref_val  = REF_W'(dig);
        end else begin
          dol1     = 1'b1;
          chr_emit = !is_dol;
          phase_nx = is_dol ? PH_DOLLAR : PH_TEXT;
        end
      end
      PH_DIGIT: begin
        need_ref = 1'b1;
        if (is_digit) begin
          ref_val = REF_W'(held_q) * REF_W'(RADIX) + REF_W'(dig);
        end else begin
          ref_val  = REF_W'(held_q);
          chr_emit = !is_dol;
          phase_nx = is_dol ? PH_DOLLAR : PH_TEXT;
        end
      end
      PH_TEXT: begin
        chr_emit = !is_dol;
        phase_nx = is_dol ? PH_DOLLAR : PH_TEXT;
      end
      default: begin
        chr_emit = !is_dol;
        phase_nx = is_dol ? PH_DOLLAR : PH_TEXT;
      end
    endcase
    ref_bad     = need_ref && (ref_val >= REF_W'(NUM_ARGS));
    ref_slot    = (ref_val == '0) ? SW'(ZERO_REF_SLOT) : SW'(ref_val - REF_W'(1));
    tail_vld_nx = chr_emit || (last_in && (phase_nx == PH_DOLLAR));
    tail_chr_nx = chr_emit ? in_data_i.in_char : DOLLAR_CHAR;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && is_line && !drop_q && !ref_bad) begin
          if (need_ref) begin
            state_d = ST_LEN;
          end else if (dol1 && tail_vld_nx) begin
            state_d = ST_TAIL;
          end
        end
      end
      ST_LEN: begin
        state_d = (len_eff == '0) ? ST_TAIL : ST_EXP;
      end
      ST_EXP: begin
        if (can_load && (rem_q == LW'(1))) begin
          state_d = tail_vld_q ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (can_load || (!tail_vld_q && !last_q)) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    drop_d     = drop_q;
    rem_d      = rem_q;
    pos_d      = pos_q;
    base_d     = base_q;
    tail_vld_d = tail_vld_q;
    tail_chr_d = tail_chr_q;
    last_d     = last_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && out_stall_i;
    arg_we     = 1'b0;
    arg_re     = 1'b0;
    len_we     = 1'b0;
    len_re     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          priority if (in_data_i.op == OP_ARG_BYTE) begin
            arg_we = slot_ok && pos_ok;
          end else if (in_data_i.op == OP_ARG_LEN) begin
            len_we = slot_ok;
          end else if (is_line && drop_q) begin
            if (last_in) begin
              drop_d  = 1'b0;
              phase_d = PH_TEXT;
            end
          end else if (is_line) begin
            phase_d    = (last_in || ref_bad) ? PH_TEXT : phase_nx;
            held_d     = held_nx;
            drop_d     = ref_bad && !last_in;
            tail_chr_d = tail_chr_nx;
            tail_vld_d = 1'b0;
            last_d     = last_in;
            pos_d      = '0;
            base_d     = AW'(ref_slot) * AW'(ARG_LEN);
            priority if (ref_bad) begin
              out_d     = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
              out_vld_d = 1'b1;
            end else if (need_ref) begin
              len_re     = 1'b1;
              tail_vld_d = tail_vld_nx;
            end else if (dol1) begin
              out_d      = mk_res(DOLLAR_CHAR, 1'b1, 1'b0, last_in && !tail_vld_nx);
              out_vld_d  = 1'b1;
              tail_vld_d = tail_vld_nx;
            end else if (tail_vld_nx) begin
              out_d     = mk_res(tail_chr_nx, 1'b1, 1'b0, last_in);
              out_vld_d = 1'b1;
            end else if (last_in) begin
              out_d     = mk_res(8'h00, 1'b0, 1'b0, 1'b1);
              out_vld_d = 1'b1;
            end else begin
              out_vld_d = out_vld_q && out_stall_i;
            end
          end else begin
            out_vld_d = out_vld_q && out_stall_i;
          end
        end
      end
      ST_LEN: begin
        rem_d = len_eff;
        if (len_eff != '0) begin
          arg_re = 1'b1;
          pos_d  = pos_q + LW'(1);
        end
      end
      ST_EXP: begin
        if (can_load) begin
          out_d     = mk_res(arg_rd_q, 1'b1, 1'b0,
                             last_q && (rem_q == LW'(1)) && !tail_vld_q);
          out_vld_d = 1'b1;
          rem_d     = rem_q - LW'(1);
          if (rem_q != LW'(1)) begin
            arg_re = 1'b1;
            pos_d  = pos_q + LW'(1);
          end
        end
      end
      ST_TAIL: begin
        if (can_load) begin
          if (tail_vld_q) begin
            out_d      = mk_res(tail_chr_q, 1'b1, 1'b0, last_q);
            out_vld_d  = 1'b1;
            tail_vld_d = 1'b0;
          end else if (last_q) begin
            out_d     = mk_res(8'h00, 1'b0, 1'b0, 1'b1);
            out_vld_d = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_TEXT;
      held_q       <= '0;
      drop_q       <= 1'b0;
      tail_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
      len_vld_q    <= '0;
      len_rd_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      held_q     <= held_d;
      drop_q     <= drop_d;
      tail_vld_q <= tail_vld_d;
      out_vld_q  <= out_vld_d;
      if (len_we) begin
        len_vld_q[wr_slot] <= 1'b1;
      end
      if (len_re) begin
        len_rd_vld_q <= len_vld_q[ref_slot];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    pos_q      <= pos_d;
    base_q     <= base_d;
    tail_chr_q <= tail_chr_d;
    last_q     <= last_d;
    out_q      <= out_d;
  end

  // argument byte memory
  always_ff @(posedge clk_i) begin
    if (arg_we) begin
      arg_mem[wr_addr] <= in_data_i.in_char;
    end
    if (arg_re) begin
      arg_rd_q <= arg_mem[rd_addr];
    end
  end

  // argument length memory
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[wr_slot] <= len_sat;
    end
    if (len_re) begin
      len_rd_q <= len_mem[ref_slot];
    end
  end

  `MAS_ASSERT_IMP(a_exp_count, clk_i, rst_ni, state_q == ST_EXP, rem_q != '0, "expansion with no bytes left")
  `MAS_ASSERT_IMP(a_err_ends_line, clk_i, rst_ni, out_vld_q && out_q.bad_ref, out_q.line_done && !out_q.has_char, "error transaction malformed")
  `MAS_ASSERT_IMP(a_drop_plain, clk_i, rst_ni, drop_q, phase_q == PH_TEXT, "reference pending while dropping a line")
  `MAS_ASSERT_NXT(a_len_once, clk_i, rst_ni, state_q == ST_LEN, state_q == ST_EXP || state_q == ST_TAIL, "length lookup did not advance")

endmodule

`default_nettype wire
